// ===== rtl/rsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rsc_pkg;

  localparam int ENTRY_W  = 48;
  localparam int OP_W     = 3;
  localparam int PUSH_W   = 31;
  localparam int STATUS_W = 3;

  localparam logic [ENTRY_W-1:0] MAG_LIMIT = {1'b1, {(ENTRY_W-1){1'b0}}};
  localparam logic [ENTRY_W-1:0] POS_MAX   = {1'b0, {(ENTRY_W-1){1'b1}}};

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_UNDERFLOW = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_DIV_ZERO  = 3'd3,
    STAT_SAT       = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_EXEC,
    CS_WAIT
  } calc_state_e;

  typedef enum logic [1:0] {
    ALU_IDLE,
    ALU_MUL,
    ALU_DIV,
    ALU_FIN
  } alu_state_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TAKE_UP,
    CELL_TAKE_DOWN
  } cell_cmd_e;

  typedef enum logic [1:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP
  } stk_op_e;

  typedef struct packed {
    logic start;
    logic div;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic sat;
  } alu_rsp_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] value;
    logic               sat;
  } fix_t;

  // Clamp a sign and magnitude into the signed entry range.
  function automatic fix_t saturate(input logic neg, input logic [ENTRY_W-1:0] mag,
                                    input logic big);
    fix_t r;
    r.sat   = 1'b0;
    r.value = mag;
    if (neg) begin
      if (big || (mag > MAG_LIMIT)) begin
        r.sat   = 1'b1;
        r.value = MAG_LIMIT;
      end else begin
        r.value = '0 - mag;
      end
    end else if (big || mag[ENTRY_W-1]) begin
      r.sat   = 1'b1;
      r.value = POS_MAX;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rpn_stack_calculator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Four-entry RPN stack of signed fixed-point words (Q31.16 by default). Present an item on
// operation_i/push_value_i with start while busy is low; the block takes it at that edge.
// Exactly one result follows, shown for a single cycle with done_o high; it cannot be held
// off, so capture it then. Push, add, subtract, the error cases and unused codes finish in
// the execute state. Multiply waits on the shift-add multiplier, retiring one multiplier
// bit per cycle; divide waits on the restoring divider, producing one quotient bit per
// cycle. Busy stays high until the result is shown, so no new item is taken before it.
module rpn_stack_calculator #(
  parameter int STACK_DEPTH   = 4,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic        [rsc_pkg::OP_W-1:0]       operation_i,
  input  wire logic        [rsc_pkg::PUSH_W-1:0]     push_value_i,
  output logic                                       done_o,
  output logic signed      [rsc_pkg::ENTRY_W-1:0]    top_value_o,
  output logic             [$clog2(STACK_DEPTH+1)-1:0] stack_depth_o,
  output logic             [rsc_pkg::STATUS_W-1:0]   status_o
);
  import rsc_pkg::*;

  localparam int DEPTH_W    = $clog2(STACK_DEPTH + 1);
  localparam int PUSH_EXT_W = ENTRY_W + PUSH_W + FRACTION_BITS;

  calc_state_e state_q, state_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic               done_q, done_d;
  status_e            status_q, status_d;

  logic [OP_W-1:0]    op_q;
  logic [PUSH_W-1:0]  pv_q;

  stk_op_e            stk_op;
  logic [ENTRY_W-1:0] new_val;
  logic [ENTRY_W-1:0] entry [STACK_DEPTH];

  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;
  logic [ENTRY_W-1:0] alu_result;

  logic [PUSH_EXT_W-1:0] push_ext;
  fix_t                  push_fix;
  logic [ENTRY_W:0]      sum;
  logic                  sum_ovf;
  logic [ENTRY_W-1:0]    sum_val;

  assign push_ext = PUSH_EXT_W'(pv_q) << FRACTION_BITS;
  assign push_fix = saturate(1'b0, push_ext[ENTRY_W-1:0],
                             |push_ext[PUSH_EXT_W-1:ENTRY_W]);

  always_comb begin
    if (op_q == OP_SUB) begin
      sum = {entry[1][ENTRY_W-1], entry[1]} - {entry[0][ENTRY_W-1], entry[0]};
    end else begin
      sum = {entry[1][ENTRY_W-1], entry[1]} + {entry[0][ENTRY_W-1], entry[0]};
    end
  end

  assign sum_ovf = sum[ENTRY_W] ^ sum[ENTRY_W-1];
  assign sum_val = sum_ovf ? (sum[ENTRY_W] ? MAG_LIMIT : POS_MAX) : sum[ENTRY_W-1:0];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [ENTRY_W-1:0] up, down;
    cell_cmd_e          cmd;

    if (i == 0) begin : g_top
      assign up = new_val;
    end else begin : g_mid
      assign up = entry[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_last
      assign down = '0;
    end else begin : g_inner
      assign down = entry[i+1];
    end

    always_comb begin
      case (stk_op)
        STK_PUSH: cmd = CELL_TAKE_UP;
        STK_POP:  cmd = (i == 0) ? CELL_TAKE_UP : CELL_TAKE_DOWN;
        default:  cmd = CELL_HOLD;
      endcase
    end

    rsc_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .up_i    (up),
      .down_i  (down),
      .value_o (entry[i])
    );
  end

  rsc_alu #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .y_i      (entry[1]),
    .x_i      (entry[0]),
    .rsp_o    (alu_rsp),
    .result_o (alu_result)
  );

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      op_q <= operation_i;
      pv_q <= push_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= CS_IDLE;
      depth_q  <= '0;
      done_q   <= 1'b0;
      status_q <= STAT_OK;
    end else begin
      state_q  <= state_d;
      depth_q  <= depth_d;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    depth_d  = depth_q;
    done_d   = 1'b0;
    status_d = status_q;
    stk_op   = STK_HOLD;
    new_val  = push_fix.value;
    alu_req  = '0;
    unique case (state_q)
      CS_IDLE: begin
        if (start) begin
          state_d = CS_EXEC;
        end
      end
      CS_EXEC: begin
        state_d  = CS_IDLE;
        done_d   = 1'b1;
        status_d = STAT_OK;
        unique case (op_q)
          OP_PUSH: begin
            if (depth_q == DEPTH_W'(STACK_DEPTH)) begin
              status_d = STAT_FULL;
            end else begin
              stk_op   = STK_PUSH;
              depth_d  = depth_q + 1'b1;
              status_d = push_fix.sat ? STAT_SAT : STAT_OK;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (depth_q < DEPTH_W'(2)) begin
              status_d = STAT_UNDERFLOW;
            end else if ((op_q == OP_ADD) || (op_q == OP_SUB)) begin
              stk_op   = STK_POP;
              new_val  = sum_val;
              depth_d  = depth_q - 1'b1;
              status_d = sum_ovf ? STAT_SAT : STAT_OK;
            end else if ((op_q == OP_DIV) && (entry[0] == '0)) begin
              status_d = STAT_DIV_ZERO;
            end else begin
              alu_req.start = 1'b1;
              alu_req.div   = (op_q == OP_DIV);
              done_d        = 1'b0;
              state_d       = CS_WAIT;
            end
          end
          default: status_d = STAT_OK;
        endcase
      end
      CS_WAIT: begin
        new_val = alu_result;
        if (alu_rsp.done) begin
          stk_op   = STK_POP;
          depth_d  = depth_q - 1'b1;
          status_d = alu_rsp.sat ? STAT_SAT : STAT_OK;
          done_d   = 1'b1;
          state_d  = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  assign busy          = (state_q != CS_IDLE);
  assign done_o        = done_q;
  assign stack_depth_o = depth_q;
  assign status_o      = status_q;
  assign top_value_o   = (depth_q != '0) ? entry[0] : '0;

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_depth_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> $stable(stack_depth_o))
    else $error("depth changed without a result");

  a_error_keeps_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ((status_o == STAT_UNDERFLOW) || (status_o == STAT_FULL) ||
                (status_o == STAT_DIV_ZERO))) |-> $stable(stack_depth_o))
    else $error("error result changed the stack depth");

  a_alu_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> (state_q == CS_WAIT))
    else $error("arithmetic unit finished outside the wait state");

endmodule

`default_nettype wire

// ===== rtl/rsc_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsc_cell (
  input  wire logic                         clk_i,
  input  wire rsc_pkg::cell_cmd_e           cmd_i,
  input  wire logic [rsc_pkg::ENTRY_W-1:0]  up_i,
  input  wire logic [rsc_pkg::ENTRY_W-1:0]  down_i,
  output logic      [rsc_pkg::ENTRY_W-1:0]  value_o
);
  import rsc_pkg::*;

  logic [ENTRY_W-1:0] value_q;

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CELL_TAKE_UP:   value_q <= up_i;
      CELL_TAKE_DOWN: value_q <= down_i;
      default:        value_q <= value_q;
    endcase
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

// ===== rtl/rsc_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsc_alu #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire rsc_pkg::alu_req_t            req_i,
  input  wire logic [rsc_pkg::ENTRY_W-1:0]  y_i,
  input  wire logic [rsc_pkg::ENTRY_W-1:0]  x_i,
  output rsc_pkg::alu_rsp_t                 rsp_o,
  output logic      [rsc_pkg::ENTRY_W-1:0]  result_o
);
  import rsc_pkg::*;

  localparam int NUM_W  = ENTRY_W + FRACTION_BITS + 1;
  localparam int STEP_W = $clog2(NUM_W);

  alu_state_e state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;

  logic                 div_q;
  logic                 neg_q;
  logic [ENTRY_W-1:0]   b_q;
  logic [ENTRY_W-1:0]   p_hi_q;
  logic [ENTRY_W-1:0]   p_lo_q;
  logic [ENTRY_W-1:0]   rem_q;
  logic [NUM_W-1:0]     num_q;

  logic [ENTRY_W-1:0]   mag_y, mag_x;
  logic [ENTRY_W-1:0]   addend;
  logic [ENTRY_W:0]     mul_sum;
  logic [ENTRY_W:0]     rem_sh;
  logic [ENTRY_W:0]     rem_diff;
  logic                 rem_ge;
  logic [2*ENTRY_W-1:0] prod;
  fix_t                 fin;

  assign mag_y    = y_i[ENTRY_W-1] ? ('0 - y_i) : y_i;
  assign mag_x    = x_i[ENTRY_W-1] ? ('0 - x_i) : x_i;
  assign addend   = p_lo_q[0] ? b_q : '0;
  assign mul_sum  = {1'b0, p_hi_q} + {1'b0, addend};
  assign rem_sh   = {rem_q, num_q[NUM_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, b_q};
  assign rem_diff = rem_sh - {1'b0, b_q};
  assign prod     = {p_hi_q, p_lo_q};

  always_comb begin
    if (div_q) begin
      fin = saturate(neg_q, num_q[ENTRY_W-1:0], |num_q[NUM_W-1:ENTRY_W]);
    end else begin
      fin = saturate(neg_q, prod[ENTRY_W+FRACTION_BITS-1:FRACTION_BITS],
                     |prod[2*ENTRY_W-1:ENTRY_W+FRACTION_BITS]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ALU_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ALU_IDLE: begin
        if (req_i.start) begin
          state_d = req_i.div ? ALU_DIV : ALU_MUL;
          cnt_d   = req_i.div ? STEP_W'(NUM_W - 1) : STEP_W'(ENTRY_W - 1);
        end
      end
      ALU_MUL, ALU_DIV: begin
        if (cnt_q == '0) begin
          state_d = ALU_FIN;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ALU_FIN: state_d = ALU_IDLE;
      default: state_d = ALU_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ALU_IDLE) && req_i.start) begin
      div_q  <= req_i.div;
      neg_q  <= y_i[ENTRY_W-1] ^ x_i[ENTRY_W-1];
      b_q    <= mag_x;
      p_hi_q <= '0;
      p_lo_q <= mag_y;
      rem_q  <= '0;
      num_q  <= NUM_W'(mag_y) << FRACTION_BITS;
    end else if (state_q == ALU_MUL) begin
      p_hi_q <= mul_sum[ENTRY_W:1];
      p_lo_q <= {mul_sum[0], p_lo_q[ENTRY_W-1:1]};
    end else if (state_q == ALU_DIV) begin
      rem_q <= rem_ge ? rem_diff[ENTRY_W-1:0] : rem_sh[ENTRY_W-1:0];
      num_q <= {num_q[NUM_W-2:0], rem_ge};
    end
  end

  assign rsp_o.done = (state_q == ALU_FIN);
  assign rsp_o.sat  = fin.sat;
  assign result_o   = fin.value;

endmodule

`default_nettype wire

// ===== dv/tb_rpn_stack_calculator.sv =====
`timescale 1ns / 1ps

module tb_rpn_stack_calculator;
  import rsc_pkg::*;

  localparam int STACK_SLOTS = 4;
  localparam int FRAC        = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int SHOWN_LIMIT = 10;
  localparam logic [PUSH_W-1:0] PUSH_MAX = '1;

  typedef struct packed {
    logic [ENTRY_W-1:0] top;
    logic [2:0]         depth;
    status_e            status;
  } calc_result_t;

  typedef struct packed {
    logic               sat;
    logic [ENTRY_W-1:0] value;
  } clamped_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  start        = 1'b0;
  logic [OP_W-1:0]       operation_i  = '0;
  logic [PUSH_W-1:0]     push_value_i = '0;
  logic                  busy;
  logic                  done_o;
  logic [ENTRY_W-1:0]    top_value_o;
  logic [2:0]            stack_depth_o;
  logic [STATUS_W-1:0]   status_o;

  logic [ENTRY_W-1:0] calc_stack [STACK_SLOTS];
  int                 calc_depth = 0;
  calc_result_t       expected_results [$];

  bit gaps_on         = 1'b1;
  int items_sent      = 0;
  int results_checked = 0;
  int mismatch_count  = 0;
  int stall_cycles    = 0;
  int status_seen [8];

  rpn_stack_calculator uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .operation_i  (operation_i),
    .push_value_i (push_value_i),
    .done_o       (done_o),
    .top_value_o  (top_value_o),
    .stack_depth_o(stack_depth_o),
    .status_o     (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [127:0] entry_mag(input logic [ENTRY_W-1:0] v);
    logic [ENTRY_W-1:0] m;
    m = v[ENTRY_W-1] ? ('0 - v) : v;
    return 128'(m);
  endfunction

  function automatic clamped_t clamp_entry(input logic neg, input logic [127:0] mag);
    clamped_t c;
    c.sat = 1'b0;
    if (neg) begin
      if (mag > 128'(MAG_LIMIT)) begin
        c.sat   = 1'b1;
        c.value = MAG_LIMIT;
      end else begin
        c.value = '0 - mag[ENTRY_W-1:0];
      end
    end else if (mag > 128'(POS_MAX)) begin
      c.sat   = 1'b1;
      c.value = POS_MAX;
    end else begin
      c.value = mag[ENTRY_W-1:0];
    end
    return c;
  endfunction

  function automatic calc_result_t step_stack(input logic [OP_W-1:0] op,
                                              input logic [PUSH_W-1:0] pv);
    calc_result_t       res;
    clamped_t           cl;
    logic               sat;
    logic               neg;
    logic [ENTRY_W-1:0] y, x;
    logic [127:0]       ym, xm, mag;
    longint             sum;
    sat        = 1'b0;
    res.status = STAT_OK;
    if (op == OP_PUSH) begin
      if (calc_depth >= STACK_SLOTS) begin
        res.status = STAT_FULL;
      end else begin
        cl = clamp_entry(1'b0, 128'(pv) << FRAC);
        sat = cl.sat;
        calc_stack[calc_depth] = cl.value;
        calc_depth++;
      end
    end else if (op <= OP_DIV) begin
      if (calc_depth < 2) begin
        res.status = STAT_UNDERFLOW;
      end else if (op == OP_DIV && calc_stack[calc_depth-1] == '0) begin
        res.status = STAT_DIV_ZERO;
      end else begin
        x   = calc_stack[calc_depth-1];
        y   = calc_stack[calc_depth-2];
        ym  = entry_mag(y);
        xm  = entry_mag(x);
        neg = y[ENTRY_W-1] ^ x[ENTRY_W-1];
        case (op)
          OP_ADD, OP_SUB: begin
            if (op == OP_ADD) sum = longint'($signed(y)) + longint'($signed(x));
            else sum = longint'($signed(y)) - longint'($signed(x));
            neg = sum < 0;
            mag = 128'(neg ? -sum : sum);
          end
          OP_MUL: mag = (ym * xm) >> FRAC;
          default: mag = (ym << FRAC) / xm;
        endcase
        cl = clamp_entry(neg, mag);
        sat = cl.sat;
        calc_depth--;
        calc_stack[calc_depth-1] = cl.value;
      end
    end
    if (sat && res.status == STAT_OK) res.status = STAT_SAT;
    res.top   = calc_depth > 0 ? calc_stack[calc_depth-1] : '0;
    res.depth = 3'(calc_depth);
    return res;
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [PUSH_W-1:0] pv);
    int           gap;
    calc_result_t res;
    gap = gaps_on ? $urandom_range(0, 9) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start        = 1'b1;
    operation_i  = op;
    push_value_i = pv;
    do @(posedge clk_i); while (busy !== 1'b0);
    res = step_stack(op, pv);
    expected_results.push_back(res);
    status_seen[res.status]++;
    items_sent++;
  endtask

  task automatic wait_results_drained();
    @(negedge clk_i);
    start = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [PUSH_W-1:0] random_push_value();
    case ($urandom_range(0, 4))
      0: return PUSH_W'($urandom_range(0, 3));
      1: return PUSH_W'($urandom_range(0, 255));
      2: return PUSH_W'($urandom_range(0, 65535));
      3: return PUSH_W'($urandom);
      default: return $urandom_range(0, 1) ? PUSH_MAX : '0;
    endcase
  endfunction

  // Every arithmetic operation on an empty stack, unused codes, then too few operands.
  task automatic test_empty_stack_errors();
    for (int c = OP_ADD; c < 8; c++) send_item(OP_W'(c), PUSH_MAX);
    send_item(OP_PUSH, PUSH_MAX);
    send_item(OP_SUB, '0);
  endtask

  task automatic test_full_and_divide_by_zero();
    send_item(OP_PUSH, '0);
    send_item(OP_PUSH, 31'd3);
    send_item(OP_PUSH, '0);
    send_item(OP_PUSH, PUSH_MAX);
    send_item(OP_DIV, PUSH_MAX);
    send_item(OP_W'(OP_DIV + 1), '0);
  endtask

  task automatic test_saturation();
    send_item(OP_ADD, '0);
    send_item(OP_SUB, '0);
    send_item(OP_MUL, '0);
    send_item(OP_PUSH, PUSH_MAX);
    send_item(OP_SUB, '0);
    send_item(OP_PUSH, 31'd1);
    send_item(OP_PUSH, 31'd65536);
    send_item(OP_DIV, '0);
    send_item(OP_DIV, '0);
    send_item(OP_PUSH, PUSH_MAX);
    send_item(OP_PUSH, PUSH_MAX);
    send_item(OP_ADD, '0);
  endtask

  // Mostly well-formed programs, with some noise and error cases mixed in.
  task automatic test_random_programs(input int count);
    int              pick;
    logic [OP_W-1:0] op;
    logic [PUSH_W-1:0] pv;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) gaps_on = $urandom_range(0, 2) != 0;
      if (n % 400 == 399) wait_results_drained();
      pick = $urandom_range(0, 99);
      pv   = PUSH_W'($urandom);
      if (pick < 8) begin
        op = OP_W'($urandom);
      end else if (calc_depth < 2 || (calc_depth < STACK_SLOTS && pick < 50)) begin
        op = OP_PUSH;
        pv = random_push_value();
      end else begin
        op = OP_W'($urandom_range(OP_ADD, OP_DIV));
      end
      send_item(op, pv);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    calc_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOWN_LIMIT)
          $display("unexpected result: top %h depth %0d status %0d",
                   top_value_o, stack_depth_o, status_o);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (top_value_o !== want.top || stack_depth_o !== want.depth ||
            status_o !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= SHOWN_LIMIT)
            $display("mismatch at result %0d: expected top %h depth %0d status %0d,",
                     results_checked, want.top, want.depth, want.status,
                     " got top %h depth %0d status %0d",
                     top_value_o, stack_depth_o, status_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || done_o === 1'b1 || (start && busy === 1'b0)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_empty_stack_errors();
    test_full_and_divide_by_zero();
    test_saturation();
    wait_results_drained();
    test_random_programs(1600);
    wait_results_drained();
    repeat (100) @(posedge clk_i);
    $display("Ran %0d items, checked %0d results, %0d mismatches",
             items_sent, results_checked, mismatch_count);
    $display("Status mix: ok %0d, underflow %0d, full %0d, div-by-zero %0d, saturated %0d",
             status_seen[STAT_OK], status_seen[STAT_UNDERFLOW], status_seen[STAT_FULL],
             status_seen[STAT_DIV_ZERO], status_seen[STAT_SAT]);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
